// File: hdl/wheel_speed_pi_with_tilt_cutoff_core_macros.svh
// ----------------------------------------------------------------------------
// wheel_speed_pi_with_tilt_cutoff_core_macros.svh
// Assertion macros for the wheel speed PI core. Each expects clk and arst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_PI_WITH_TILT_CUTOFF_CORE_MACROS_SVH
`define WHEEL_SPEED_PI_WITH_TILT_CUTOFF_CORE_MACROS_SVH

// same-cycle implication
`define WSPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WSPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/wspc_pkg.sv
// ----------------------------------------------------------------------------
// wspc_pkg
// Shared widths, register indexes, payload types and defaults for the wheel
// speed PI core.
// ----------------------------------------------------------------------------
package wspc_pkg;

	localparam int DEF_FILTER_FRAC_BITS = 8;
	localparam int DEF_GAIN_FRAC_BITS   = 12;

	localparam int CNT_W   = 16;
	localparam int FILT_W  = 26;
	localparam int GAIN_W  = 24;
	localparam int LIMIT_W = 20;
	localparam int TILT_W  = 15;
	localparam int DRIVE_W = 32;

	// digit-serial units work on 4-bit digits
	localparam int DIG_W       = 4;
	localparam int GAIN_DIGITS = GAIN_W / DIG_W;

	// divide by 5: remainder fits in 3 bits, quotient digit via reciprocal
	localparam int REM_W        = 3;
	localparam int RECIP5       = 205;
	localparam int RECIP5_SHIFT = 10;

	// integral width follows the clamp bound (limit << frac bits)
	localparam int DEF_INT_W = (DEF_FILTER_FRAC_BITS + LIMIT_W + 1 > 30) ?
		DEF_FILTER_FRAC_BITS + LIMIT_W + 1 : 30;
	localparam int DEF_NUM_W = ((CNT_W + 1 + DEF_FILTER_FRAC_BITS > FILT_W + 2) ?
		CNT_W + 1 + DEF_FILTER_FRAC_BITS : FILT_W + 2) + 1;
	localparam int DEF_DIV_DIGITS = (DEF_NUM_W + DIG_W - 1) / DIG_W;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT     = 2'd3;

	localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 20'd10000;
	localparam logic [TILT_W-1:0]  TILT_LIMIT_RST     = 15'd6000;

	typedef struct packed {
		logic signed [CNT_W-1:0] left_count;
		logic signed [CNT_W-1:0] right_count;
		logic signed [CNT_W-1:0] tilt_angle;
		logic signed [CNT_W-1:0] speed_target;
	} item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] speed_drive;
		logic                      tilt_fault;
	} result_t;

	// status of a digit-serial unit
	typedef struct packed {
		logic busy;
		logic done;
	} ser_stat_t;

endpackage

// File: hdl/wspc_stream_if.sv
// ----------------------------------------------------------------------------
// wspc_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface wspc_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/wspc_div5.sv
// ----------------------------------------------------------------------------
// wspc_div5
// Digit-serial unsigned divide by five, one 4-bit digit per cycle, MSD first.
// ----------------------------------------------------------------------------
module wspc_div5 import wspc_pkg::*; #(
	parameter int NUM_DIGITS = DEF_DIV_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [NUM_DIGITS*DIG_W-1:0]   dividend,
	output logic [NUM_DIGITS*DIG_W-1:0]   quotient,
	output ser_stat_t                     stat
);

	localparam int DW = NUM_DIGITS * DIG_W;
	localparam int CW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int VW = REM_W + DIG_W;
	localparam int PW = VW + 8;

	logic [DW-1:0]    num_q;
	logic [DW-1:0]    quot_q;
	logic [REM_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VW-1:0]    part;
	logic [PW-1:0]    prod;
	logic [DIG_W-1:0] qd;
	logic [VW-1:0]    rem_full;

	always_comb begin
		part     = {rem_q, num_q[DW-1 -: DIG_W]};
		// part < 80, so part*205 >> 10 is the exact quotient
		prod     = PW'(part) * PW'(RECIP5);
		qd       = DIG_W'(prod >> RECIP5_SHIFT);
		rem_full = part - (VW'(qd) << 2) - VW'(qd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NUM_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << DIG_W;
			rem_q  <= REM_W'(rem_full);
			quot_q <= {quot_q[DW-DIG_W-1:0], qd};
		end
	end

	assign quotient  = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: hdl/wspc_mac.sv
// ----------------------------------------------------------------------------
// wspc_mac
// Digit-serial dual multiply-accumulate: a*ka + b*kb, gains taken one 4-bit
// digit per cycle, LSD first, partial sum shifted right each step.
// ----------------------------------------------------------------------------
module wspc_mac import wspc_pkg::*; #(
	parameter int INT_W = DEF_INT_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [FILT_W-1:0]          a,
	input  logic signed [INT_W-1:0]           b,
	input  logic signed [GAIN_W-1:0]          ka,
	input  logic signed [GAIN_W-1:0]          kb,
	output logic signed [INT_W+2+GAIN_W-1:0]  acc,
	output ser_stat_t                         stat
);

	localparam int HI_W = INT_W + 2;
	localparam int T_W  = INT_W + 6;
	localparam int CW   = $clog2(GAIN_DIGITS);

	logic signed [FILT_W-1:0] a_q;
	logic signed [INT_W-1:0]  b_q;
	logic [GAIN_W-1:0]        ka_q;
	logic [GAIN_W-1:0]        kb_q;
	logic signed [HI_W-1:0]   hi_q;
	logic [GAIN_W-1:0]        lo_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic                        last;
	logic signed [DIG_W:0]       da;
	logic signed [DIG_W:0]       db;
	logic signed [FILT_W+DIG_W:0] pa;
	logic signed [INT_W+DIG_W:0]  pb;
	logic signed [T_W-1:0]       t;

	always_comb begin
		last = (cnt_q == CW'(GAIN_DIGITS - 1));
		// top digit carries the gain's sign
		da   = last ? {ka_q[DIG_W-1], ka_q[DIG_W-1:0]} : {1'b0, ka_q[DIG_W-1:0]};
		db   = last ? {kb_q[DIG_W-1], kb_q[DIG_W-1:0]} : {1'b0, kb_q[DIG_W-1:0]};
		pa   = a_q * da;
		pb   = b_q * db;
		t    = T_W'(hi_q) + T_W'(pa) + T_W'(pb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			ka_q <= ka;
			kb_q <= kb;
			hi_q <= '0;
		end else if (busy_q) begin
			ka_q <= ka_q >> DIG_W;
			kb_q <= kb_q >> DIG_W;
			hi_q <= HI_W'(t >>> DIG_W);
			lo_q <= {t[DIG_W-1:0], lo_q[GAIN_W-1:DIG_W]};
		end
	end

	assign acc       = {hi_q, lo_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: hdl/wheel_speed_pi_with_tilt_cutoff_core.sv
// ----------------------------------------------------------------------------
// wheel_speed_pi_with_tilt_cutoff_core
// Wheel speed PI controller with low-pass filter, clamped integral and tilt
// cutoff.
// ----------------------------------------------------------------------------
// One item is processed at a time. An accepted item passes through the
// prepare, divide, integral, multiply and finish states before its result is
// loaded into the output register, and the next item is taken only after
// that, as long as the output register has been emptied. DIV_DIGITS is the
// number of 4-bit digits of the filter numerator, which the serial
// divide-by-five unit retires one per cycle before handing over the quotient;
// the serial gain multiplier holds the sequencer while it works through the
// six gain digits and hands over the sum. A finished result waits in the
// output register while the next item is already being worked.
// Configuration writes take effect at once and must be made while idle.
// ----------------------------------------------------------------------------
`include "wheel_speed_pi_with_tilt_cutoff_core_macros.svh"

module wheel_speed_pi_with_tilt_cutoff_core import wspc_pkg::*; #(
	parameter int FILTER_FRAC_BITS = DEF_FILTER_FRAC_BITS,
	parameter int GAIN_FRAC_BITS   = DEF_GAIN_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [GAIN_W-1:0]     cfg_data,
	wspc_stream_if.sink           item,
	wspc_stream_if.source         result
);

	localparam int F     = FILTER_FRAC_BITS;
	localparam int INT_W = (F + LIMIT_W + 1 > 30) ? F + LIMIT_W + 1 : 30;
	localparam int NUM_W = ((CNT_W + 1 + F > FILT_W + 2) ? CNT_W + 1 + F : FILT_W + 2) + 1;
	localparam int DIV_DIGITS = (NUM_W + DIG_W - 1) / DIG_W;
	localparam int DIV_W = DIV_DIGITS * DIG_W;
	localparam int SUM_W = ((INT_W > CNT_W + F) ? INT_W : CNT_W + F) + 2;
	localparam int BND_W = LIMIT_W + F;
	localparam int ACC_W = INT_W + 2 + GAIN_W;
	localparam int SHR   = F + GAIN_FRAC_BITS;
	localparam int Q_W   = ACC_W - SHR;
	localparam int X_W   = ((Q_W > DRIVE_W) ? Q_W : DRIVE_W) + 1;

	localparam logic [DIV_W-1:0] FILT_POS_MAX = DIV_W'((64'd1 << (FILT_W - 1)) - 64'd1);
	localparam logic [DIV_W-1:0] FILT_NEG_MAG = DIV_W'(64'd1 << (FILT_W - 1));
	localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
	localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};
	localparam logic signed [X_W-1:0] DRV_MAX = {{(X_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [X_W-1:0] DRV_MIN = {{(X_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_INTG = 3'd3;
	localparam logic [2:0] ST_MAC  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// configuration
	logic signed [GAIN_W-1:0] speed_gain_q;
	logic signed [GAIN_W-1:0] integral_gain_q;
	logic [LIMIT_W-1:0]       integral_limit_q;
	logic [TILT_W-1:0]        tilt_limit_q;

	// sequencer and state
	logic [2:0]               state_q;
	item_t                    item_q;
	logic signed [FILT_W-1:0] filt_q;
	logic signed [INT_W-1:0]  int_q;
	logic                     num_neg_q;
	logic                     fault_q;
	logic                     res_valid_q;
	result_t                  res_q;

	// serial units
	logic                     div_start;
	logic [DIV_W-1:0]         div_mag;
	logic [DIV_W-1:0]         div_quot;
	ser_stat_t                div_stat;
	logic                     mac_start;
	logic signed [ACC_W-1:0]  mac_acc;
	ser_stat_t                mac_stat;

	// datapath
	logic signed [CNT_W:0]    cnt_sum;
	logic signed [NUM_W-1:0]  num;
	logic [NUM_W-1:0]         num_mag;
	logic signed [FILT_W-1:0] filt_next;
	logic signed [SUM_W-1:0]  int_sum;
	logic signed [SUM_W-1:0]  bound;
	logic signed [INT_W-1:0]  int_next;
	logic [CNT_W-1:0]         tilt_mag;
	logic                     fault_next;
	logic signed [Q_W-1:0]    drv_floor;
	logic                     drv_sticky;
	logic signed [X_W-1:0]    drv_wide;
	logic signed [DRIVE_W-1:0] drive;
	logic                     out_free;

	wspc_div5 #(
		.NUM_DIGITS (DIV_DIGITS)
	) u_div5 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	wspc_mac #(
		.INT_W (INT_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.a      (filt_q),
		.b      (int_next),
		.ka     (speed_gain_q),
		.kb     (integral_gain_q),
		.acc    (mac_acc),
		.stat   (mac_stat)
	);

	always_comb begin
		// filter numerator: 4*old + (sum << F), divided by 5 in the serial unit
		cnt_sum = (CNT_W+1)'(item_q.left_count) + (CNT_W+1)'(item_q.right_count);
		num     = (NUM_W'(filt_q) <<< 2) + (NUM_W'(cnt_sum) <<< F);
		num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		div_mag = DIV_W'(num_mag);

		if (!num_neg_q) begin
			filt_next = (div_quot > FILT_POS_MAX) ? FILT_MAX : FILT_W'(div_quot);
		end else begin
			filt_next = (div_quot > FILT_NEG_MAG) ? FILT_MIN : FILT_W'(-FILT_W'(div_quot));
		end

		int_sum = SUM_W'(int_q) + SUM_W'(filt_q) - (SUM_W'(item_q.speed_target) <<< F);
		bound   = SUM_W'({integral_limit_q, {F{1'b0}}});
		if (int_sum > bound) begin
			int_next = INT_W'(bound);
		end else if (int_sum < -bound) begin
			int_next = INT_W'(-bound);
		end else begin
			int_next = INT_W'(int_sum);
		end

		tilt_mag   = item_q.tilt_angle[CNT_W-1] ? CNT_W'(-item_q.tilt_angle)
		                                        : CNT_W'(item_q.tilt_angle);
		fault_next = tilt_mag > CNT_W'(tilt_limit_q);

		// truncate toward zero: floor, then bump negatives with a nonzero fraction
		drv_floor  = mac_acc[ACC_W-1:SHR];
		drv_sticky = |mac_acc[SHR-1:0];
		drv_wide   = X_W'(drv_floor) + X_W'(mac_acc[ACC_W-1] && drv_sticky);
		if (drv_wide > DRV_MAX) begin
			drive = DRIVE_W'(DRV_MAX);
		end else if (drv_wide < DRV_MIN) begin
			drive = DRIVE_W'(DRV_MIN);
		end else begin
			drive = DRIVE_W'(drv_wide);
		end

		div_start = (state_q == ST_PREP);
		mac_start = (state_q == ST_INTG);
		out_free  = !res_valid_q || result.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q     <= '0;
			integral_gain_q  <= '0;
			integral_limit_q <= INTEGRAL_LIMIT_RST;
			tilt_limit_q     <= TILT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED_GAIN:     speed_gain_q     <= cfg_data;
				REG_INTEGRAL_GAIN:  integral_gain_q  <= cfg_data;
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_TILT_LIMIT:     tilt_limit_q     <= cfg_data[TILT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filt_q      <= '0;
			int_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						filt_q  <= filt_next;
						state_q <= ST_INTG;
					end
				end
				ST_INTG: begin
					// the MAC takes the clamped value; a fault clears what is kept
					int_q   <= fault_next ? '0 : int_next;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (mac_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid) begin
			item_q <= item.data;
		end
		if (state_q == ST_PREP) begin
			num_neg_q <= num[NUM_W-1];
		end
		if (state_q == ST_INTG) begin
			fault_q <= fault_next;
		end
		if (state_q == ST_FIN && out_free) begin
			res_q.speed_drive <= drive;
			res_q.tilt_fault  <= fault_q;
		end
	end

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	`WSPC_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == ST_DIV,
		"divider finished outside the divide phase")
	`WSPC_ASSERT_IMP(a_mac_done_in_mac, mac_stat.done, state_q == ST_MAC,
		"multiplier finished outside the multiply phase")
	`WSPC_ASSERT_NXT(a_fault_clears_int, (state_q == ST_INTG) && fault_next, int_q == '0,
		"tilt fault did not clear the integral")

endmodule

// File: bench/wspc_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspc_drive_checker
// Watches the register port and both stream channels of the wheel speed PI
// core. Keeps its own filter, integral and register state, predicts the drive
// and fault flag for every accepted tick and compares each accepted result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module wspc_drive_checker import wspc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  item_t                item_data,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  result_t              result_data,
	output int                   fail_count,
	output int                   pending
);

	localparam longint SCALE     = longint'(1) << DEF_FILTER_FRAC_BITS;
	localparam longint DRIVE_DIV = longint'(1) << (DEF_FILTER_FRAC_BITS + DEF_GAIN_FRAC_BITS);
	localparam longint FILT_HI   = (longint'(1) << (FILT_W - 1)) - 1;
	localparam longint FILT_LO   = -(longint'(1) << (FILT_W - 1));
	localparam longint DRIVE_HI  = (longint'(1) << (DRIVE_W - 1)) - 1;
	localparam longint DRIVE_LO  = -(longint'(1) << (DRIVE_W - 1));

	longint  speed_gain_q;
	longint  integral_gain_q;
	longint  integral_limit_q;
	longint  tilt_limit_q;
	longint  filtered_q;
	longint  integral_q;
	result_t drive_expect_q[$];
	int      result_idx;

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// advances the filter and integral by one tick, returns drive and fault
	function automatic result_t predict_drive(item_t it);
		longint  sum;
		longint  bound;
		longint  acc;
		longint  drv;
		longint  angle;
		result_t r;
		sum        = longint'(it.left_count) + longint'(it.right_count);
		filtered_q = clip((4 * filtered_q + sum * SCALE) / 5, FILT_LO, FILT_HI);
		bound      = integral_limit_q * SCALE;
		integral_q = clip(integral_q + filtered_q - longint'(it.speed_target) * SCALE,
			-bound, bound);
		acc = filtered_q * speed_gain_q + integral_q * integral_gain_q;
		// SV division truncates toward zero
		drv   = clip(acc / DRIVE_DIV, DRIVE_LO, DRIVE_HI);
		angle = longint'(it.tilt_angle);
		if (angle < 0)
			angle = -angle;
		r.speed_drive = drv[DRIVE_W-1:0];
		r.tilt_fault  = (angle > tilt_limit_q);
		// drive of a fault tick is formed before the integral is cleared
		if (r.tilt_fault)
			integral_q = 0;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("[%0t] result %0d: %s mismatch, expected %0d, got %0d",
			$time, result_idx, what, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			speed_gain_q     = 0;
			integral_gain_q  = 0;
			integral_limit_q = longint'(INTEGRAL_LIMIT_RST);
			tilt_limit_q     = longint'(TILT_LIMIT_RST);
			filtered_q       = 0;
			integral_q       = 0;
			drive_expect_q.delete();
			pending          = 0;
			result_idx       = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPEED_GAIN:     speed_gain_q     = longint'($signed(cfg_data));
					REG_INTEGRAL_GAIN:  integral_gain_q  = longint'($signed(cfg_data));
					REG_INTEGRAL_LIMIT: integral_limit_q = longint'(cfg_data[LIMIT_W-1:0]);
					REG_TILT_LIMIT:     tilt_limit_q     = longint'(cfg_data[TILT_W-1:0]);
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (drive_expect_q.size() == 0) begin
					report_mismatch("unexpected transaction, speed_drive", 0,
						longint'(result_data.speed_drive));
				end else begin
					want = drive_expect_q.pop_front();
					if (result_data.speed_drive !== want.speed_drive)
						report_mismatch("speed_drive", longint'(want.speed_drive),
							longint'(result_data.speed_drive));
					if (result_data.tilt_fault !== want.tilt_fault)
						report_mismatch("tilt_fault", longint'(want.tilt_fault),
							longint'(result_data.tilt_fault));
				end
				result_idx++;
			end
			if (item_valid && item_ready)
				drive_expect_q.push_back(predict_drive(item_data));
			pending = drive_expect_q.size();
		end
	end

endmodule

// File: bench/tb_wheel_speed_pi_with_tilt_cutoff_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wheel_speed_pi_with_tilt_cutoff_core
// Drives control ticks and register settings into the wheel speed PI core
// under several idle/stall patterns, including one long output hold-off, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_wheel_speed_pi_with_tilt_cutoff_core import wspc_pkg::*;;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 4;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 5000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data  = '0;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	int holds_requested;
	int holds_served;
	int quiet_cycles;

	wspc_stream_if #(.data_t(item_t))   item_ch ();
	wspc_stream_if #(.data_t(result_t)) result_ch ();

	wheel_speed_pi_with_tilt_cutoff_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	wspc_drive_checker u_drive_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_data    (item_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// nothing accepted on either channel for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stalls plus a long hold-off when one is requested
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served < holds_requested) begin
				holds_served++;
				repeat (HOLD_CYCLES) begin
					result_ch.ready <= 1'b0;
					@(negedge clk);
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic item_t make_tick(int l, int r, int a, int t);
		item_t it;
		it.left_count   = l[CNT_W-1:0];
		it.right_count  = r[CNT_W-1:0];
		it.tilt_angle   = a[CNT_W-1:0];
		it.speed_target = t[CNT_W-1:0];
		return it;
	endfunction

	function automatic logic [CNT_W-1:0] count_near(int m);
		int v;
		v = int'($urandom_range(2 * m)) - m;
		return v[CNT_W-1:0];
	endfunction

	function automatic logic [GAIN_W-1:0] gain_near(int m);
		int v;
		v = int'($urandom_range(2 * m)) - m;
		return v[GAIN_W-1:0];
	endfunction

	// mostly plausible ticks so the integral builds up between faults,
	// the rest raw bit patterns
	function automatic item_t random_tick();
		item_t it;
		if ($urandom_range(99) < 85) begin
			it.left_count   = count_near(2000);
			it.right_count  = count_near(2000);
			it.speed_target = count_near(600);
			it.tilt_angle   = ($urandom_range(99) < 80) ? count_near(3000) : count_near(18000);
		end else begin
			it = item_t'({$urandom(), $urandom()});
		end
		return it;
	endfunction

	task automatic send_tick(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do
			@(posedge clk);
		while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [GAIN_W-1:0] sg, input logic [GAIN_W-1:0] ig,
		input logic [GAIN_W-1:0] lim, input logic [GAIN_W-1:0] tl);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SPEED_GAIN;
		cfg_data  <= sg;
		@(negedge clk);
		cfg_index <= REG_INTEGRAL_GAIN;
		cfg_data  <= ig;
		@(negedge clk);
		cfg_index <= REG_INTEGRAL_LIMIT;
		cfg_data  <= lim;
		@(negedge clk);
		cfg_index <= REG_TILT_LIMIT;
		cfg_data  <= tl;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		item_ch.valid  = 1'b0;
		item_ch.data   = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset register values: tilt boundary is strict
		send_tick(make_tick(0, 0, 0, 0));
		send_tick(make_tick(100, 200, 6000, 0));
		send_tick(make_tick(100, 200, 6001, 0));
		wait_drained();

		apply_settings(24'd4096, 24'd4096, 24'd10000, 24'd6000);
		send_tick(make_tick(32767, 32767, 0, 0));
		send_tick(make_tick(32767, 32767, 0, 0));
		send_tick(make_tick(32767, 32767, -6000, -32768));
		send_tick(make_tick(-32768, -32768, -6001, 32767));
		send_tick(make_tick(-32768, -32768, 18000, 0));
		send_tick(make_tick(32767, -32768, -18000, 0));
		send_tick(make_tick(0, 0, -32768, 0));
		send_tick(make_tick(0, 0, 32767, 32767));
		send_tick(make_tick(-1, -1, -1, -1));
		// drive the integral into its clamp
		repeat (4) send_tick(make_tick(1, 1, 1, -32768));
		send_tick(make_tick(0, 0, 0, 0));

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: apply_settings(24'd4096, 24'd2048, 24'd10000, 24'd6000);
				1: apply_settings(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFF, 24'h7FFF);
				2: apply_settings(24'h800000, 24'h800000, 24'd0, 24'd0);
				3: apply_settings(GAIN_W'($urandom()), GAIN_W'($urandom()), 24'd1000000,
					24'd18000);
				4: apply_settings(gain_near(65536), gain_near(65536),
					GAIN_W'($urandom_range(50000)), GAIN_W'($urandom_range(18000)));
				5: apply_settings(24'd0, gain_near(1 << 20), GAIN_W'($urandom_range(20000)),
					24'h7FFF);
				6: apply_settings(GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()),
					GAIN_W'($urandom()));
				default: apply_settings(gain_near(65536), GAIN_W'($urandom()), 24'd1000,
					24'd9000);
			endcase
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct  = 30;
					recv_stall_pct = 30;
				end
			endcase
			// sender keeps offering while the output is held off
			if (p == 2)
				holds_requested++;
			repeat (PHASE_ITEMS) send_tick(random_tick());
		end

		wait_drained();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
